@@ design/ncvdac_pkg.sv @@
// Shared types, codes and tables for the note to CV DAC converter.
package ncvdac_pkg;

    localparam int NUM_OUTPUTS = 4;
    localparam int CH_W        = 2;

    // Event kinds.
    localparam logic [2:0] KIND_NOTE_1V  = 3'd0;
    localparam logic [2:0] KIND_NOTE_1V2 = 3'd1;
    localparam logic [2:0] KIND_NOTE_HZV = 3'd2;
    localparam logic [2:0] KIND_7BIT     = 3'd3;
    localparam logic [2:0] KIND_BEND     = 3'd4;
    localparam logic [2:0] KIND_VOLTS    = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CAL_SCALE  = 2'd0;
    localparam logic [1:0] CFG_CAL_OFFSET = 2'd1;
    localparam logic [1:0] CFG_VOLTS      = 2'd2;

    localparam logic [11:0] HZV_BASE_72  = 12'd4000;
    localparam logic [9:0]  HZV_NOTE_72  = 10'd72;
    localparam logic [47:0] RECIP_3      = 48'd11184811;  // ceil(2^25 / 3)
    localparam logic [15:0] RECIP_12     = 16'd171;       // 2^11 / 12, rounded up
    localparam logic [12:0] CAL_UNITY    = 13'd4032;      // 4096 - 64
    localparam logic [11:0] DAC_MAX      = 12'd4095;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_ALIGN,
        ST_CAL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic step1;
        logic step2;
        logic step3;
        logic step4;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic out_blocked;
    } t_status;

    // Base codes for the twelve semitones of the top Hz/V octave.
    function automatic logic [11:0] hzv_base(input logic [3:0] idx);
        logic [11:0] v;
        case (idx)
            4'd0:    v = 12'd2000;
            4'd1:    v = 12'd2119;
            4'd2:    v = 12'd2245;
            4'd3:    v = 12'd2378;
            4'd4:    v = 12'd2520;
            4'd5:    v = 12'd2670;
            4'd6:    v = 12'd2828;
            4'd7:    v = 12'd2997;
            4'd8:    v = 12'd3175;
            4'd9:    v = 12'd3364;
            4'd10:   v = 12'd3564;
            4'd11:   v = 12'd3775;
            default: v = 12'd2000;
        endcase
        return v;
    endfunction

endpackage

@@ design/ncvdac_ctrl.sv @@
// Sequencer that steps one event through the conversion datapath.
module ncvdac_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  ncvdac_pkg::t_status i_status,
    output logic               o_in_stall,
    output ncvdac_pkg::t_cmd   o_cmd
);

    ncvdac_pkg::t_state r_state;
    ncvdac_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ncvdac_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ncvdac_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ncvdac_pkg::ST_MUL1;
                end
            end
            ncvdac_pkg::ST_MUL1:  n_state = ncvdac_pkg::ST_MUL2;
            ncvdac_pkg::ST_MUL2:  n_state = ncvdac_pkg::ST_ALIGN;
            ncvdac_pkg::ST_ALIGN: n_state = ncvdac_pkg::ST_CAL;
            ncvdac_pkg::ST_CAL:   n_state = ncvdac_pkg::ST_DONE;
            ncvdac_pkg::ST_DONE: begin
                if (!i_status.out_blocked) begin
                    n_state = ncvdac_pkg::ST_IDLE;
                end
            end
            default: n_state = ncvdac_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ncvdac_pkg::ST_IDLE: begin
                o_in_stall    = !i_rst_n;
                o_cmd.capture = i_in_valid && i_rst_n;
            end
            ncvdac_pkg::ST_MUL1:  o_cmd.step1 = 1'b1;
            ncvdac_pkg::ST_MUL2:  o_cmd.step2 = 1'b1;
            ncvdac_pkg::ST_ALIGN: o_cmd.step3 = 1'b1;
            ncvdac_pkg::ST_CAL:   o_cmd.step4 = 1'b1;
            ncvdac_pkg::ST_DONE:  o_cmd.finish = !i_status.out_blocked;
            default: o_cmd = '0;
        endcase
    end

endmodule

@@ design/ncvdac_dp.sv @@
// Conversion datapath: configuration registers, arithmetic, code cache and result register.
module ncvdac_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ncvdac_pkg::t_cmd    i_cmd,
    output ncvdac_pkg::t_status o_status,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [27:0]         i_cfg_data,
    input  logic [2:0]          i_kind,
    input  logic [1:0]          i_output_index,
    input  logic [6:0]          i_note,
    input  logic signed [15:0]  i_bend,
    input  logic [13:0]         i_level,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [1:0]          o_channel,
    output logic [11:0]         o_dac_code,
    output logic                o_changed
);

    // Configuration.
    logic        r_cfg_rdy;
    logic [27:0] r_cal_scale;
    logic [27:0] r_cal_offset;
    logic [15:0] r_volts;

    // Captured event.
    logic [2:0]         r_kind;
    logic [1:0]         r_ch;
    logic [13:0]        r_level;
    logic signed [17:0] r_n;

    // Intermediate results.
    logic [23:0]        r_m1;
    logic               r_neg;
    logic [11:0]        r_base;
    logic [15:0]        r_frac244;
    logic [2:0]         r_oct;
    logic [21:0]        r_quot;
    logic [27:0]        r_hprod;
    logic signed [24:0] r_val;
    logic signed [38:0] r_cal;
    logic               r_g_nz;
    logic [6:0]         r_off;

    logic [11:0] r_cache [ncvdac_pkg::NUM_OUTPUTS];

    logic        r_out_valid;
    logic [1:0]  r_out_ch;
    logic [11:0] r_out_code;
    logic        r_out_chg;

    // Capture.
    logic signed [17:0] cap_n;

    // Step 1.
    logic [17:0]        neg_n;
    logic [16:0]        abs_n;
    logic [7:0]         wb;
    logic [15:0]        qm;
    logic [4:0]         q12;
    logic [7:0]         q12x;
    logic [7:0]         rem8;
    logic [3:0]         vfield;
    logic [3:0]         vsat;
    logic [6:0]         lvl7;
    logic [11:0]        k3v;
    logic [17:0]        k4v;
    logic [22:0]        k5v;
    logic signed [24:0] ext_n;
    logic signed [24:0] p50;
    logic signed [24:0] s1_val;

    // Steps 2 and 3.
    logic [47:0]        qprod;
    logic signed [22:0] sq;
    logic signed [22:0] sq_sh;
    logic [12:0]        b2;
    logic [12:0]        b2_sh;
    logic signed [24:0] s3_val;

    // Step 4.
    logic [4:0]         pos7;
    logic [6:0]         g;
    logic [12:0]        factor;

    // Finish.
    logic signed [38:0] adj;
    logic signed [38:0] divd;
    logic signed [38:0] calv;
    logic signed [38:0] fval;
    logic [11:0]        clamped;
    logic [11:0]        cached;
    logic               kind_ok;
    logic [11:0]        code;
    logic               chg;

    assign o_cfg_ready = r_cfg_rdy;
    assign o_status.out_blocked = r_out_valid && i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_channel   = r_out_ch;
    assign o_dac_code  = r_out_code;
    assign o_changed   = r_out_chg;

    always_comb begin
        cap_n = $signed({3'b000, i_note, 8'b0000_0000}) + $signed({{2{i_bend[15]}}, i_bend});
    end

    always_comb begin
        neg_n  = 18'(-r_n);
        abs_n  = r_n[17] ? neg_n[16:0] : r_n[16:0];
        // Note number is the floor of n / 256; only its low byte selects octave and semitone.
        wb     = r_n[15:8];
        qm     = 16'(wb) * ncvdac_pkg::RECIP_12;
        q12    = qm[15:11];
        q12x   = 8'(q12) * 8'd12;
        rem8   = wb - q12x;
        vfield = r_volts[{r_ch, 2'b00} +: 4];
        vsat   = (vfield > 4'd8) ? 4'd8 : vfield;
        lvl7   = (r_level > 14'd127) ? 7'd127 : r_level[6:0];
        k3v    = 12'(lvl7) * 12'(vsat);
        k4v    = 18'(r_level) * 18'(vsat);
        k5v    = 23'(r_level) * 23'd500;
        ext_n  = $signed({{7{r_n[17]}}, r_n});
        p50    = ext_n * 25'sd50;
        case (r_kind)
            ncvdac_pkg::KIND_NOTE_1V2: s1_val = p50 >>> 8;
            ncvdac_pkg::KIND_7BIT:     s1_val = $signed({13'b0, k3v[9:0], 2'b00});
            ncvdac_pkg::KIND_BEND:     s1_val = $signed({12'b0, k4v[17:5]});
            ncvdac_pkg::KIND_VOLTS:    s1_val = $signed({2'b00, k5v});
            default:                   s1_val = '0;
        endcase
    end

    always_comb begin
        qprod  = 48'(r_m1) * ncvdac_pkg::RECIP_3;
        sq     = r_neg ? -$signed({1'b0, r_quot}) : $signed({1'b0, r_quot});
        sq_sh  = sq >>> 8;
        b2     = 13'(r_base) + 13'(r_hprod[27:20]);
        b2_sh  = b2 >> (3'd5 - r_oct);
        case (r_kind)
            ncvdac_pkg::KIND_NOTE_1V:  s3_val = $signed({{2{sq_sh[22]}}, sq_sh});
            ncvdac_pkg::KIND_NOTE_HZV: s3_val = $signed({12'b0, b2_sh});
            default:                   s3_val = r_val;
        endcase
    end

    always_comb begin
        pos7   = 5'(r_ch) * 5'd7;
        g      = r_cal_scale[pos7 +: 7];
        factor = ncvdac_pkg::CAL_UNITY + 13'(g);
    end

    always_comb begin
        // Truncating division by 4096 rounds toward zero for negative products.
        adj     = r_cal + (r_cal[38] ? 39'sd4095 : 39'sd0);
        divd    = adj >>> 12;
        calv    = divd + $signed({32'b0, r_off}) - 39'sd64;
        fval    = r_g_nz ? calv : $signed({{14{r_val[24]}}, r_val});
        if (fval[38]) begin
            clamped = '0;
        end else if (fval > 39'sd4095) begin
            clamped = ncvdac_pkg::DAC_MAX;
        end else begin
            clamped = fval[11:0];
        end
        cached  = r_cache[r_ch];
        kind_ok = (r_kind <= ncvdac_pkg::KIND_VOLTS);
        code    = kind_ok ? clamped : cached;
        chg     = kind_ok && (clamped != cached);
    end

    // Control state and storage with a reset value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rdy    <= 1'b0;
            r_cal_scale  <= '0;
            r_cal_offset <= '0;
            r_volts      <= '0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < ncvdac_pkg::NUM_OUTPUTS; i++) begin
                r_cache[i] <= '0;
            end
        end else begin
            r_cfg_rdy <= 1'b1;
            if (i_cfg_valid && r_cfg_rdy) begin
                case (i_cfg_index)
                    ncvdac_pkg::CFG_CAL_SCALE:  r_cal_scale  <= i_cfg_data;
                    ncvdac_pkg::CFG_CAL_OFFSET: r_cal_offset <= i_cfg_data;
                    ncvdac_pkg::CFG_VOLTS:      r_volts      <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
                if (chg) begin
                    r_cache[r_ch] <= clamped;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= i_kind;
            r_ch    <= i_output_index;
            r_level <= i_level;
            r_n     <= cap_n;
        end
        if (i_cmd.step1) begin
            r_m1      <= 24'(abs_n) * 24'd125;
            r_neg     <= r_n[17];
            r_base    <= (r_n[17:8] == ncvdac_pkg::HZV_NOTE_72) ? ncvdac_pkg::HZV_BASE_72
                                                               : ncvdac_pkg::hzv_base(rem8[3:0]);
            r_frac244 <= 16'(r_n[7:0]) * 16'd244;
            r_oct     <= (q12 > 5'd5) ? 3'd5 : q12[2:0];
            r_val     <= s1_val;
        end
        if (i_cmd.step2) begin
            r_quot  <= qprod[46:25];
            r_hprod <= 28'(r_base) * 28'(r_frac244);
        end
        if (i_cmd.step3) begin
            r_val <= s3_val;
        end
        if (i_cmd.step4) begin
            r_cal  <= $signed({{14{r_val[24]}}, r_val}) * $signed({26'b0, factor});
            r_g_nz <= (g != 7'd0);
            r_off  <= r_cal_offset[pos7 +: 7];
        end
        if (i_cmd.finish) begin
            r_out_ch   <= r_ch;
            r_out_code <= code;
            r_out_chg  <= chg;
        end
    end

endmodule

@@ design/note_to_cv_dac_converter.sv @@
// Top level of the note to CV DAC converter.
//
// Each input transaction carries one control event (kind, output_index, note,
// bend, level) for one of four DAC outputs. The block turns it into a 12-bit
// code, applies the per-output calibration, clamps to 0..4095 and compares the
// code with the one held for that output. One result transaction follows per
// event, carrying the channel, the code and a flag that is set when the code
// differs from the held one.
// An event goes through the capture, four arithmetic steps (reciprocal
// multiply and table lookup, calibration multiply) on one sequencer and the
// loading of the result register. The input is stalled while an event is in
// work: a new event is taken only once the last one has loaded its result.
// While the receiver stalls, the result register holds its transaction; the
// next event is still accepted and waits in its last step until the register
// frees up. Configuration writes go through a valid/ready port, register
// index 0 for calibration gains, 1 for offsets and 2 for volt ranges; the
// user must make them while the block is idle, as the block does not enforce
// it. Reset clears the configuration registers and the held codes to zero.
module note_to_cv_dac_converter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_kind,
    input  logic [1:0]         i_output_index,
    input  logic [6:0]         i_note,
    input  logic signed [15:0] i_bend,
    input  logic [13:0]        i_level,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_channel,
    output logic [11:0]        o_dac_code,
    output logic               o_changed,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [27:0]        i_cfg_data
);

    ncvdac_pkg::t_cmd    cmd;
    ncvdac_pkg::t_status status;

    ncvdac_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    ncvdac_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_kind         (i_kind),
        .i_output_index (i_output_index),
        .i_note         (i_note),
        .i_bend         (i_bend),
        .i_level        (i_level),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_channel      (o_channel),
        .o_dac_code     (o_dac_code),
        .o_changed      (o_changed)
    );

endmodule

@@ design/ncvdac_chk.sv @@
// Port-level checker for the note to CV DAC converter and its bind.
module ncvdac_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_channel,
    input logic [11:0] o_dac_code,
    input logic        o_changed
);

    // An accepted event keeps the input stalled through its arithmetic steps.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall ##1 o_in_stall ##1 o_in_stall ##1 o_in_stall)
        else $error("input taken again before the event finished");

    // A new result only appears at the end of an event's work.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without an event in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_channel)
            && $stable(o_dac_code) && $stable(o_changed)))
        else $error("stalled result transaction changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind note_to_cv_dac_converter ncvdac_chk u_ncvdac_chk (.*);

@@ tb/tb.sv @@
// Self-checking testbench for the note to CV DAC converter, scoring every result against a predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] KIND_SPARE_6   = 3'd6;
    localparam logic [2:0] KIND_SPARE_7   = 3'd7;
    localparam logic [1:0] CFG_UNUSED     = 2'd3;
    localparam int         IDLE_PCT       = 9;
    localparam int         WATCHDOG_LIMIT = 3000;
    localparam int         DRAIN_TAIL     = 20;
    localparam int         PHASES         = 8;
    localparam int         PHASE_ITEMS    = 200;
    localparam int         CALM_PHASE     = 3;
    localparam int         HZV_TOP_OCTAVE [12] = '{
        2000, 2119, 2245, 2378, 2520, 2670, 2828, 2997, 3175, 3364, 3564, 3775
    };

    typedef struct packed {
        logic [1:0]  channel;
        logic [11:0] code;
        logic        changed;
    } t_code_entry;

    // Tracks the configuration and the code held per output, and queues the
    // result that each accepted event must produce.
    class dac_code_tracker;
        logic [27:0] gain_reg;
        logic [27:0] offset_reg;
        logic [15:0] range_reg;
        logic [11:0] held_code [ncvdac_pkg::NUM_OUTPUTS];
        t_code_entry expected_codes [$];
        int          errors;

        function void clear();
            gain_reg   = '0;
            offset_reg = '0;
            range_reg  = '0;
            foreach (held_code[i]) held_code[i] = '0;
            expected_codes.delete();
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [27:0] data);
            case (idx)
                ncvdac_pkg::CFG_CAL_SCALE:  gain_reg   = data;
                ncvdac_pkg::CFG_CAL_OFFSET: offset_reg = data;
                ncvdac_pkg::CFG_VOLTS:      range_reg  = data[15:0];
                default: ;
            endcase
        endfunction

        function int outstanding();
            return expected_codes.size();
        endfunction

        function void take_event(logic [2:0] kind, logic [1:0] ch, logic [6:0] note,
                                 logic signed [15:0] bend, logic [13:0] level);
            longint      n, lvl, value, frac, w, base, gain, offs, volts;
            int          sh, wb, oct;
            t_code_entry e;
            sh    = int'(ch);
            n     = longint'(note) * 256 + longint'(bend);
            lvl   = longint'(level);
            volts = longint'((range_reg >> (4 * sh)) & 16'hF);
            if (volts > 8) volts = 8;
            e.channel = ch;
            e.changed = 1'b0;
            case (kind)
                ncvdac_pkg::KIND_NOTE_1V:  value = ((n * 500) / 12) >>> 8;
                ncvdac_pkg::KIND_NOTE_1V2: value = ((n * 600) / 12) >>> 8;
                ncvdac_pkg::KIND_NOTE_HZV: begin
                    frac = n & 255;
                    w    = n >>> 8;
                    wb   = int'(w & 255);
                    base = (w == 72) ? 4000 : HZV_TOP_OCTAVE[wb % 12];
                    base = base + (base * 244 * frac) / 1048576;
                    oct  = wb / 12;
                    if (oct > 5) oct = 5;
                    value = base >>> (5 - oct);
                end
                ncvdac_pkg::KIND_7BIT:     value = ((lvl > 127) ? 127 : lvl) * volts * 4;
                ncvdac_pkg::KIND_BEND:     value = (lvl * volts) >>> 5;
                ncvdac_pkg::KIND_VOLTS:    value = lvl * 500;
                default: begin
                    // Unused kinds leave the held code alone and report it.
                    e.code = held_code[ch];
                    expected_codes.push_back(e);
                    return;
                end
            endcase
            gain = longint'((gain_reg >> (7 * sh)) & 28'h7F);
            if (gain != 0) begin
                offs  = longint'((offset_reg >> (7 * sh)) & 28'h7F) - 64;
                value = (value * (4096 + gain - 64)) / 4096 + offs;
            end
            if (value < 0) value = 0;
            else if (value > 4095) value = 4095;
            e.code = value[11:0];
            if (e.code != held_code[ch]) begin
                held_code[ch] = e.code;
                e.changed     = 1'b1;
            end
            expected_codes.push_back(e);
        endfunction

        function void match_result(logic [1:0] ch, logic [11:0] code, logic changed);
            t_code_entry e;
            if (expected_codes.size() == 0) begin
                $display("%0t: unexpected result channel %0d code %0d changed %0d",
                         $time, ch, code, changed);
                errors++;
                return;
            end
            e = expected_codes.pop_front();
            if (ch !== e.channel) begin
                $display("%0t: channel expected %0d, got %0d", $time, e.channel, ch);
                errors++;
            end
            if (code !== e.code) begin
                $display("%0t: dac_code on channel %0d expected %0d, got %0d",
                         $time, e.channel, e.code, code);
                errors++;
            end
            if (changed !== e.changed) begin
                $display("%0t: changed on channel %0d expected %0d, got %0d",
                         $time, e.channel, e.changed, changed);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n        = 1'b0;
    logic               i_in_valid     = 1'b0;
    logic               o_in_stall;
    logic [2:0]         i_kind         = '0;
    logic [1:0]         i_output_index = '0;
    logic [6:0]         i_note         = '0;
    logic signed [15:0] i_bend         = '0;
    logic [13:0]        i_level        = '0;
    logic               o_out_valid;
    logic               i_out_stall    = 1'b0;
    logic [1:0]         o_channel;
    logic [11:0]        o_dac_code;
    logic               o_changed;
    logic               i_cfg_valid    = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index    = '0;
    logic [27:0]        i_cfg_data     = '0;

    dac_code_tracker tracker;
    bit              gaps_on      = 1'b1;
    int              quiet_cycles = 0;

    note_to_cv_dac_converter DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_output_index (i_output_index),
        .i_note         (i_note),
        .i_bend         (i_bend),
        .i_level        (i_level),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_channel      (o_channel),
        .o_dac_code     (o_dac_code),
        .o_changed      (o_changed),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_stall <= gaps_on && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            tracker.match_result(o_channel, o_dac_code, o_changed);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // The event is noted in the predictor at the edge that accepts the transaction.
    task automatic send_event(input logic [2:0] kind, input logic [1:0] ch,
                              input logic [6:0] note, input logic signed [15:0] bend,
                              input logic [13:0] level);
        while (gaps_on && ($urandom_range(99) < IDLE_PCT)) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_kind         <= kind;
        i_output_index <= ch;
        i_note         <= note;
        i_bend         <= bend;
        i_level        <= level;
        do @(posedge i_clk); while (o_in_stall);
        tracker.take_event(kind, ch, note, bend, level);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [27:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.set_reg(idx, data);
    endtask

    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
    endtask

    // Registers change only once every pending result has come back.
    task automatic reconfigure(input logic [27:0] gains, input logic [27:0] offsets,
                               input logic [15:0] ranges, input bit poke_unused);
        wait_results_done();
        write_reg(ncvdac_pkg::CFG_CAL_SCALE, gains);
        write_reg(ncvdac_pkg::CFG_CAL_OFFSET, offsets);
        write_reg(ncvdac_pkg::CFG_VOLTS, {12'($urandom), ranges});
        if (poke_unused) write_reg(CFG_UNUSED, 28'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [2:0]         r_kind;
        logic [1:0]         r_ch;
        logic [6:0]         r_note;
        logic signed [15:0] r_bend;
        logic [13:0]        r_level;
        logic [27:0]        cfg_gain;
        logic [27:0]        cfg_offs;
        logic [15:0]        cfg_volts;
        int                 pick;
        bit                 have_prev;

        tracker = new;
        tracker.clear();
        have_prev = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: no calibration, zero volt ranges.
        send_event(ncvdac_pkg::KIND_NOTE_1V, 2'd0, 7'd0, 16'sd0, 14'd0);
        send_event(ncvdac_pkg::KIND_NOTE_1V, 2'd0, 7'd120, 16'sd32767, 14'd0);
        send_event(ncvdac_pkg::KIND_NOTE_1V, 2'd0, 7'd0, -16'sd32768, 14'd0);
        send_event(ncvdac_pkg::KIND_NOTE_1V2, 2'd1, 7'd60, -16'sd128, 14'd0);
        send_event(ncvdac_pkg::KIND_NOTE_1V2, 2'd1, 7'd127, 16'sd32767, 14'd16383);
        send_event(ncvdac_pkg::KIND_NOTE_HZV, 2'd2, 7'd72, 16'sd0, 14'd0);
        send_event(ncvdac_pkg::KIND_NOTE_HZV, 2'd2, 7'd72, 16'sd255, 14'd0);
        send_event(ncvdac_pkg::KIND_NOTE_HZV, 2'd2, 7'd0, -16'sd32768, 14'd0);
        send_event(ncvdac_pkg::KIND_NOTE_HZV, 2'd3, 7'd120, 16'sd32767, 14'd0);
        send_event(ncvdac_pkg::KIND_NOTE_HZV, 2'd3, 7'd71, -16'sd1, 14'd0);
        send_event(ncvdac_pkg::KIND_VOLTS, 2'd3, 7'd0, 16'sd0, 14'd16383);
        send_event(KIND_SPARE_6, 2'd3, 7'd0, 16'sd0, 14'd0);
        send_event(KIND_SPARE_7, 2'd2, 7'd127, -16'sd1, 14'd16383);
        send_event(ncvdac_pkg::KIND_7BIT, 2'd0, 7'd0, 16'sd0, 14'd127);

        // Maximum gain on output 0, minimum on 1, unity on 2, none on 3;
        // volt ranges 8, 15, 3 and 9 so both saturate cases show up.
        reconfigure(28'd127 | (28'd1 << 7) | (28'd64 << 14),
                    28'd127 | (28'd64 << 14) | (28'd5 << 21), 16'h93F8, 1'b0);
        send_event(ncvdac_pkg::KIND_7BIT, 2'd0, 7'd0, 16'sd0, 14'd16383);
        send_event(ncvdac_pkg::KIND_7BIT, 2'd1, 7'd0, 16'sd0, 14'd128);
        send_event(ncvdac_pkg::KIND_7BIT, 2'd3, 7'd0, 16'sd0, 14'd127);
        send_event(ncvdac_pkg::KIND_BEND, 2'd2, 7'd0, 16'sd0, 14'd16383);
        send_event(ncvdac_pkg::KIND_BEND, 2'd1, 7'd0, 16'sd0, 14'd0);
        send_event(ncvdac_pkg::KIND_VOLTS, 2'd1, 7'd0, 16'sd0, 14'd1);
        send_event(ncvdac_pkg::KIND_NOTE_1V, 2'd1, 7'd0, -16'sd32768, 14'd0);
        send_event(ncvdac_pkg::KIND_NOTE_HZV, 2'd0, 7'd72, 16'sd128, 14'd0);
        send_event(KIND_SPARE_6, 2'd0, 7'd5, 16'sd0, 14'd0);
        send_event(ncvdac_pkg::KIND_NOTE_1V2, 2'd3, 7'd64, 16'sd0, 14'd0);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    cfg_gain = '0;
                    cfg_offs = '0;
                    cfg_volts = '0;
                end
                1: begin
                    cfg_gain = '1;
                    cfg_offs = '1;
                    cfg_volts = '1;
                end
                2: begin
                    cfg_gain = 28'h8102040;  // unity gain on every output
                    cfg_offs = 28'h8102040;  // zero offset on every output
                    cfg_volts = 16'h8888;
                end
                5: begin
                    cfg_gain = '0;
                    cfg_offs = 28'($urandom);
                    cfg_volts = 16'($urandom);
                end
                default: begin
                    cfg_gain = 28'($urandom);
                    cfg_offs = 28'($urandom);
                    cfg_volts = 16'($urandom);
                end
            endcase
            reconfigure(cfg_gain, cfg_offs, cfg_volts, p == 4);
            gaps_on = (p != CALM_PHASE);
            for (int j = 0; j < PHASE_ITEMS; j++) begin
                // Repeating an event exercises the unchanged-code path.
                if (!(have_prev && ($urandom_range(99) < 15))) begin
                    pick = $urandom_range(99);
                    r_kind = (pick < 6) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
                    r_ch = 2'($urandom_range(3));
                    r_note = ($urandom_range(9) == 0) ? 7'($urandom_range(127))
                                                      : 7'($urandom_range(120));
                    pick = $urandom_range(9);
                    if (pick < 2)
                        r_bend = '0;
                    else if (pick < 6)
                        r_bend = 16'($urandom_range(511)) ^
                                 (($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000);
                    else
                        r_bend = 16'($urandom);
                    pick = $urandom_range(9);
                    if (pick < 4)
                        r_level = 14'($urandom_range(127));
                    else if (pick < 6)
                        r_level = 14'($urandom_range(255));
                    else
                        r_level = 14'($urandom_range(16383));
                    have_prev = 1'b1;
                end
                send_event(r_kind, r_ch, r_note, r_bend, r_level);
            end
        end

        gaps_on = 1'b1;
        wait_results_done();
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (tracker.outstanding() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, tracker.outstanding());
            tracker.errors++;
        end
        if (tracker.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
